// File: design/elfv_pkg.sv
// ----------------------------------------------------------------------------
// elfv_pkg
// Shared types and constants of the elf64 image validator: item and result
// records, status, opcode and register index codes.
// ----------------------------------------------------------------------------
package elfv_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [55:0] IDENT_GOOD = 56'h010102464C457F;
  localparam logic [15:0] TYPE_EXEC = 16'd2;
  localparam logic [15:0] MACH_X86_64 = 16'd62;
  localparam logic [15:0] PHDR_BYTES = 16'd56;
  localparam logic [63:0] EHDR_BYTES = 64'd64;
  localparam logic [31:0] PT_LOADABLE = 32'd1;

  typedef enum logic {
    OP_FILE_HDR = 1'b0,
    OP_PROG_HDR = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_REGION  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_BYTES  = 2'd0,
    CFG_REGION_START = 2'd1,
    CFG_REGION_BYTES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'b01,
    PH_COLLECT = 2'b10
  } phase_e;

  // classified request, as it waits in the queue
  typedef struct packed {
    op_e         op;
    logic        hdr_ok;
    logic        load;
    logic        bad_file;
    logic        bad_region;
    logic [15:0] count;
    logic [63:0] address;
    logic [63:0] seg_end;
    logic [31:0] fsz;
    logic [31:0] msz;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        last;
    logic [63:0] low_address;
    logic [63:0] high_address;
    logic [15:0] load_count;
    logic [31:0] file_total;
    logic [31:0] mem_total;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: design/elfv_front.sv
// ----------------------------------------------------------------------------
// elfv_front
// Configuration registers and request classification: all checks that depend
// only on the request and the configuration.
// ----------------------------------------------------------------------------
module elfv_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [elfv_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [elfv_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                op_i,
  input  logic [55:0]                         ident_i,
  input  logic [15:0]                         file_type_i,
  input  logic [15:0]                         machine_i,
  input  logic [15:0]                         entry_size_i,
  input  logic [15:0]                         header_count_i,
  input  logic [63:0]                         offset_i,
  input  logic [63:0]                         address_i,
  input  logic [31:0]                         seg_type_i,
  input  logic [63:0]                         file_size_i,
  input  logic [63:0]                         mem_size_i,
  output elfv_pkg::item_t                     item_o,
  output logic [63:0]                         region_start_o,
  output logic [63:0]                         region_bytes_o
);

  logic [63:0] image_bytes_q, region_start_q, region_bytes_q;
  logic [21:0] table_len;
  logic        fsz_gt_msz;

  function automatic logic fits_image(input logic [63:0] off, input logic [63:0] len,
                                      input logic [63:0] img);
    logic [63:0] room;
    room = img - len;
    return (len <= img) && (off <= room);
  endfunction

  function automatic logic fits_region(input logic [63:0] va, input logic [63:0] len,
                                       input logic [63:0] rs, input logic [63:0] rb);
    logic [63:0] rel;
    logic [63:0] room;
    rel  = va - rs;
    room = rb - len;
    return (va >= rs) && (len <= rb) && (rel <= room);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_bytes_q  <= '0;
      region_start_q <= '0;
      region_bytes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        elfv_pkg::CFG_IMAGE_BYTES:  image_bytes_q  <= cfg_wdata_i;
        elfv_pkg::CFG_REGION_START: region_start_q <= cfg_wdata_i;
        elfv_pkg::CFG_REGION_BYTES: region_bytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // count * 56 as (count << 6) - (count << 3)
  assign table_len  = {header_count_i, 6'b0} - {3'b0, header_count_i, 3'b0};
  assign fsz_gt_msz = file_size_i > mem_size_i;

  assign region_start_o = region_start_q;
  assign region_bytes_o = region_bytes_q;

  always_comb begin
    item_o.op = elfv_pkg::op_e'(op_i);
    item_o.hdr_ok = (image_bytes_q >= elfv_pkg::EHDR_BYTES) &&
                    (ident_i == elfv_pkg::IDENT_GOOD) &&
                    (file_type_i == elfv_pkg::TYPE_EXEC) &&
                    (machine_i == elfv_pkg::MACH_X86_64) &&
                    (entry_size_i == elfv_pkg::PHDR_BYTES) &&
                    (header_count_i != 16'd0) &&
                    fits_image(offset_i, {42'b0, table_len}, image_bytes_q);
    item_o.load       = seg_type_i == elfv_pkg::PT_LOADABLE;
    item_o.bad_file   = fsz_gt_msz || !fits_image(offset_i, file_size_i, image_bytes_q);
    item_o.bad_region = !fits_region(address_i, mem_size_i, region_start_q, region_bytes_q);
    item_o.count      = header_count_i;
    item_o.address    = address_i;
    item_o.seg_end    = address_i + mem_size_i;
    item_o.fsz        = file_size_i[31:0];
    item_o.msz        = mem_size_i[31:0];
  end

endmodule

// File: design/elfv_queue.sv
// ----------------------------------------------------------------------------
// elfv_queue
// Short request queue between the classifier and the tracking stage.
// ----------------------------------------------------------------------------
module elfv_queue #(
  parameter int unsigned Depth = elfv_pkg::QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  elfv_pkg::item_t      item_i,
  input  logic                 pop_i,
  output elfv_pkg::item_t      item_o,
  output elfv_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  elfv_pkg::item_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o         = entry_q[rd_ptr_q];
  assign status_o.full  = cnt_q == CntW'(Depth);
  assign status_o.empty = cnt_q == '0;

endmodule

// File: design/elfv_back.sv
// ----------------------------------------------------------------------------
// elfv_back
// Tracking stage: phase, header counts, address span and size totals, and the
// registered result toward the output channel.
// ----------------------------------------------------------------------------
module elfv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  elfv_pkg::item_t      item_i,
  input  elfv_pkg::q_status_t  q_status_i,
  input  logic [63:0]          region_start_i,
  input  logic [63:0]          region_bytes_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output elfv_pkg::result_t    result_o
);

  elfv_pkg::phase_e  phase_q, phase_d;
  logic [15:0]       expected_q, expected_d, seen_q, seen_d, cnt_q, cnt_d;
  logic [63:0]       entry_q, entry_d, min_q, min_d, max_q, max_d;
  logic [63:0]       entry_rel;
  logic              entry_ok;
  logic [31:0]       fsum_q, fsum_d, msum_q, msum_d;
  logic              valid_q;
  elfv_pkg::result_t res_q, res_d;
  elfv_pkg::status_e status;
  logic              last;

  assign pop_o = !q_status_i.empty && (!valid_q || out_ready_i);

  // entry point inside the user region as currently configured
  assign entry_rel = entry_q - region_start_i;
  assign entry_ok  = (entry_q >= region_start_i) && (region_bytes_i != 64'd0) &&
                     (entry_rel <= region_bytes_i - 64'd1);

  always_comb begin
    phase_d    = phase_q;
    expected_d = expected_q;
    seen_d     = seen_q;
    cnt_d      = cnt_q;
    entry_d    = entry_q;
    min_d      = min_q;
    max_d      = max_q;
    fsum_d     = fsum_q;
    msum_d     = msum_q;
    status     = elfv_pkg::ST_OK;
    last       = 1'b0;

    if (item_i.op == elfv_pkg::OP_FILE_HDR) begin
      expected_d = '0;
      seen_d     = '0;
      entry_d    = '0;
      min_d      = '1;
      max_d      = '0;
      cnt_d      = '0;
      fsum_d     = '0;
      msum_d     = '0;
      if (item_i.hdr_ok) begin
        expected_d = item_i.count;
        entry_d    = item_i.address;
        phase_d    = elfv_pkg::PH_COLLECT;
      end else begin
        phase_d = elfv_pkg::PH_IDLE;
        status  = elfv_pkg::ST_INVALID;
        last    = 1'b1;
      end
    end else if (phase_q != elfv_pkg::PH_COLLECT) begin
      status = elfv_pkg::ST_INVALID;
      last   = 1'b1;
    end else begin
      seen_d = seen_q + 16'd1;
      if (item_i.load && item_i.bad_file) begin
        phase_d = elfv_pkg::PH_IDLE;
        status  = elfv_pkg::ST_INVALID;
        last    = 1'b1;
      end else if (item_i.load && item_i.bad_region) begin
        phase_d = elfv_pkg::PH_IDLE;
        status  = elfv_pkg::ST_REGION;
        last    = 1'b1;
      end else begin
        if (item_i.load) begin
          if (item_i.address < min_q) begin
            min_d = item_i.address;
          end
          if (item_i.seg_end > max_q) begin
            max_d = item_i.seg_end;
          end
          cnt_d  = cnt_q + 16'd1;
          fsum_d = fsum_q + item_i.fsz;
          msum_d = msum_q + item_i.msz;
        end
        if (seen_d == expected_q) begin
          phase_d = elfv_pkg::PH_IDLE;
          last    = 1'b1;
          if (cnt_d == '0 || !entry_ok || entry_q < min_d || entry_q >= max_d) begin
            status = elfv_pkg::ST_INVALID;
          end
        end
      end
    end

    res_d.status       = status;
    res_d.last         = last;
    res_d.low_address  = min_d;
    res_d.high_address = max_d;
    res_d.load_count   = cnt_d;
    res_d.file_total   = fsum_d;
    res_d.mem_total    = msum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= elfv_pkg::PH_IDLE;
      expected_q <= '0;
      seen_q     <= '0;
      cnt_q      <= '0;
      entry_q    <= '0;
      min_q      <= '1;
      max_q      <= '0;
      fsum_q     <= '0;
      msum_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q    <= phase_d;
        expected_q <= expected_d;
        seen_q     <= seen_d;
        cnt_q      <= cnt_d;
        entry_q    <= entry_d;
        min_q      <= min_d;
        max_q      <= max_d;
        fsum_q     <= fsum_d;
        msum_q     <= msum_d;
        valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// File: design/elf64_image_validator_core.sv
// ----------------------------------------------------------------------------
// elf64_image_validator_core
// Validates an elf64 executable header and its program headers for loading
// into a fixed user region; one result per request.
// ----------------------------------------------------------------------------
// a request taken at the input is written into a queue entry, then popped into
// the tracking stage register as the result; throughput: one request per cycle
// while the output channel accepts results
// reset: control state, configuration and tracking state cleared at once,
// no clearing pass
module elf64_image_validator_core #(
  parameter int unsigned QueueDepth = elfv_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [elfv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [elfv_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_op_i,
  input  logic [55:0]                   in_ident_i,
  input  logic [15:0]                   in_file_type_i,
  input  logic [15:0]                   in_machine_i,
  input  logic [15:0]                   in_entry_size_i,
  input  logic [15:0]                   in_header_count_i,
  input  logic [63:0]                   in_offset_i,
  input  logic [63:0]                   in_address_i,
  input  logic [31:0]                   in_seg_type_i,
  input  logic [63:0]                   in_file_size_i,
  input  logic [63:0]                   in_mem_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_status_o,
  output logic                          out_last_o,
  output logic [63:0]                   out_low_address_o,
  output logic [63:0]                   out_high_address_o,
  output logic [15:0]                   out_load_count_o,
  output logic [31:0]                   out_file_total_o,
  output logic [31:0]                   out_mem_total_o
);

  elfv_pkg::item_t     front_item, queue_item;
  elfv_pkg::q_status_t q_status;
  elfv_pkg::result_t   result;
  logic                push, pop;
  logic [63:0]         region_start, region_bytes;

  assign in_ready_o = !q_status.full;
  assign push       = in_valid_i && in_ready_o;

  elfv_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (in_op_i),
    .ident_i        (in_ident_i),
    .file_type_i    (in_file_type_i),
    .machine_i      (in_machine_i),
    .entry_size_i   (in_entry_size_i),
    .header_count_i (in_header_count_i),
    .offset_i       (in_offset_i),
    .address_i      (in_address_i),
    .seg_type_i     (in_seg_type_i),
    .file_size_i    (in_file_size_i),
    .mem_size_i     (in_mem_size_i),
    .item_o         (front_item),
    .region_start_o (region_start),
    .region_bytes_o (region_bytes)
  );

  elfv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (q_status)
  );

  elfv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (queue_item),
    .q_status_i     (q_status),
    .region_start_i (region_start),
    .region_bytes_i (region_bytes),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result)
  );

  assign out_status_o       = result.status;
  assign out_last_o         = result.last;
  assign out_low_address_o  = result.low_address;
  assign out_high_address_o = result.high_address;
  assign out_load_count_o   = result.load_count;
  assign out_file_total_o   = result.file_total;
  assign out_mem_total_o    = result.mem_total;

  a_pending_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> out_status_o == elfv_pkg::ST_OK)
    else $error("non-final result carries an error status");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_status.empty)
    else $error("accepted request missing from queue");

  a_totals_need_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_load_count_o == 16'd0 |->
      out_file_total_o == 32'd0 && out_mem_total_o == 32'd0)
    else $error("size totals nonzero without loadable segments");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty && (!out_valid_o || out_ready_i))
    else $error("queue popped without data or output room");

endmodule

// File: dv/tb_elf64_image_validator_core.sv
// ----------------------------------------------------------------------------
// tb_elf64_image_validator_core
// Self-checking bench for the elf64 image validator. A queue of file-header
// and program-header requests is driven through the valid/ready input while
// a local model of the validation rules predicts each result. The results
// are compared field by field in order. The run steps through several region
// and image settings: reset values, a typical layout, full-range, wrapping
// top-of-memory, minimal image and empty region. The typical layout starts with
// directed images; it and the later settings run random well-formed, broken and
// noise images, with random stalls on both sides except in the full-range one.
// ----------------------------------------------------------------------------
module tb_elf64_image_validator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import elfv_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct = 18;
  localparam logic [63:0] ImageSize = 64'h0010_0000;
  localparam logic [63:0] RegionBase = 64'h0040_0000;
  localparam logic [63:0] RegionSize = 64'h0100_0000;
  localparam logic [31:0] PtDynamic = 32'd2;
  localparam logic [31:0] PtNote = 32'd4;

  typedef struct {
    op_e         op;
    logic [55:0] ident;
    logic [15:0] file_type;
    logic [15:0] machine;
    logic [15:0] entry_size;
    logic [15:0] header_count;
    logic [63:0] offset;
    logic [63:0] address;
    logic [31:0] seg_type;
    logic [63:0] file_size;
    logic [63:0] mem_size;
  } elf_req_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        in_op_i = 1'b0;
  logic [55:0] in_ident_i = '0;
  logic [15:0] in_file_type_i = '0;
  logic [15:0] in_machine_i = '0;
  logic [15:0] in_entry_size_i = '0;
  logic [15:0] in_header_count_i = '0;
  logic [63:0] in_offset_i = '0;
  logic [63:0] in_address_i = '0;
  logic [31:0] in_seg_type_i = '0;
  logic [63:0] in_file_size_i = '0;
  logic [63:0] in_mem_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_status_o;
  logic        out_last_o;
  logic [63:0] out_low_address_o;
  logic [63:0] out_high_address_o;
  logic [15:0] out_load_count_o;
  logic [31:0] out_file_total_o;
  logic [31:0] out_mem_total_o;

  elf64_image_validator_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .in_op_i            (in_op_i),
    .in_ident_i         (in_ident_i),
    .in_file_type_i     (in_file_type_i),
    .in_machine_i       (in_machine_i),
    .in_entry_size_i    (in_entry_size_i),
    .in_header_count_i  (in_header_count_i),
    .in_offset_i        (in_offset_i),
    .in_address_i       (in_address_i),
    .in_seg_type_i      (in_seg_type_i),
    .in_file_size_i     (in_file_size_i),
    .in_mem_size_i      (in_mem_size_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_status_o       (out_status_o),
    .out_last_o         (out_last_o),
    .out_low_address_o  (out_low_address_o),
    .out_high_address_o (out_high_address_o),
    .out_load_count_o   (out_load_count_o),
    .out_file_total_o   (out_file_total_o),
    .out_mem_total_o    (out_mem_total_o)
  );

  // image and region settings as last written
  logic [63:0] img_bytes_cfg = '0;
  logic [63:0] region_base_cfg = '0;
  logic [63:0] region_len_cfg = '0;

  // validation state of the current image
  phase_e      img_phase = PH_IDLE;
  logic [15:0] hdrs_expected = '0;
  logic [15:0] hdrs_seen = '0;
  logic [63:0] entry_va = '0;
  logic [63:0] lowest_va = '1;
  logic [63:0] highest_end = '0;
  logic [15:0] loadable_segs = '0;
  logic [31:0] file_bytes_sum = '0;
  logic [31:0] mem_bytes_sum = '0;

  elf_req_t    pending_reqs[$];
  result_t     expected_verdicts[$];
  elf_req_t    cur_req;
  bit          req_taken = 1'b0;
  bit          calm = 1'b0;
  int unsigned reqs_queued = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned n_accepted = 0;
  int unsigned n_invalid = 0;
  int unsigned n_region = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic bit image_holds(logic [63:0] off, logic [63:0] len);
    return len <= img_bytes_cfg && off <= img_bytes_cfg - len;
  endfunction

  function automatic bit region_holds(logic [63:0] va, logic [63:0] len);
    if (va < region_base_cfg) return 1'b0;
    return len <= region_len_cfg && (va - region_base_cfg) <= region_len_cfg - len;
  endfunction

  function automatic result_t tracking_snapshot(status_e st, logic fin);
    result_t r;
    r.status       = st;
    r.last         = fin;
    r.low_address  = lowest_va;
    r.high_address = highest_end;
    r.load_count   = loadable_segs;
    r.file_total   = file_bytes_sum;
    r.mem_total    = mem_bytes_sum;
    return r;
  endfunction

  function automatic result_t predict_verdict(elf_req_t r);
    logic [63:0] seg_end;
    bit hdr_ok;
    if (r.op == OP_FILE_HDR) begin
      hdrs_expected  = '0;
      hdrs_seen      = '0;
      entry_va       = '0;
      lowest_va      = '1;
      highest_end    = '0;
      loadable_segs  = '0;
      file_bytes_sum = '0;
      mem_bytes_sum  = '0;
      hdr_ok = img_bytes_cfg >= EHDR_BYTES && r.ident == IDENT_GOOD &&
               r.file_type == TYPE_EXEC && r.machine == MACH_X86_64 &&
               r.entry_size == PHDR_BYTES && r.header_count != 16'd0 &&
               image_holds(r.offset, 64'(r.header_count) * 64'(PHDR_BYTES));
      if (!hdr_ok) begin
        img_phase = PH_IDLE;
        return tracking_snapshot(ST_INVALID, 1'b1);
      end
      hdrs_expected = r.header_count;
      entry_va      = r.address;
      img_phase     = PH_COLLECT;
      return tracking_snapshot(ST_OK, 1'b0);
    end
    if (img_phase != PH_COLLECT) return tracking_snapshot(ST_INVALID, 1'b1);
    hdrs_seen = hdrs_seen + 16'd1;
    if (r.seg_type == PT_LOADABLE) begin
      if (r.file_size > r.mem_size || !image_holds(r.offset, r.file_size)) begin
        img_phase = PH_IDLE;
        return tracking_snapshot(ST_INVALID, 1'b1);
      end
      if (!region_holds(r.address, r.mem_size)) begin
        img_phase = PH_IDLE;
        return tracking_snapshot(ST_REGION, 1'b1);
      end
      if (r.address < lowest_va) lowest_va = r.address;
      seg_end = r.address + r.mem_size;
      if (seg_end > highest_end) highest_end = seg_end;
      loadable_segs  = loadable_segs + 16'd1;
      file_bytes_sum = file_bytes_sum + r.file_size[31:0];
      mem_bytes_sum  = mem_bytes_sum + r.mem_size[31:0];
    end
    if (hdrs_seen != hdrs_expected) return tracking_snapshot(ST_OK, 1'b0);
    img_phase = PH_IDLE;
    if (loadable_segs == 16'd0 || !region_holds(entry_va, 64'd1) ||
        entry_va < lowest_va || entry_va >= highest_end) begin
      return tracking_snapshot(ST_INVALID, 1'b1);
    end
    return tracking_snapshot(ST_OK, 1'b1);
  endfunction

  // ---------------------------------------------------------- driver side

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        cur_req = pending_reqs.pop_front();
        in_valid_i        <= 1'b1;
        in_op_i           <= cur_req.op;
        in_ident_i        <= cur_req.ident;
        in_file_type_i    <= cur_req.file_type;
        in_machine_i      <= cur_req.machine;
        in_entry_size_i   <= cur_req.entry_size;
        in_header_count_i <= cur_req.header_count;
        in_offset_i       <= cur_req.offset;
        in_address_i      <= cur_req.address;
        in_seg_type_i     <= cur_req.seg_type;
        in_file_size_i    <= cur_req.file_size;
        in_mem_size_i     <= cur_req.mem_size;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (calm || $urandom_range(0, 99) >= IdlePct);
  end

  // --------------------------------------------------------- monitor side

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t mismatch: expected no result, actual status %0d last %0d",
                   $time, out_status_o, out_last_o);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          results_checked++;
          cmp_field("status", 64'(want.status), 64'(out_status_o));
          cmp_field("last", 64'(want.last), 64'(out_last_o));
          cmp_field("low_address", want.low_address, out_low_address_o);
          cmp_field("high_address", want.high_address, out_high_address_o);
          cmp_field("load_count", 64'(want.load_count), 64'(out_load_count_o));
          cmp_field("file_total", 64'(want.file_total), 64'(out_file_total_o));
          cmp_field("mem_total", 64'(want.mem_total), 64'(out_mem_total_o));
          if (want.last) begin
            case (want.status)
              ST_OK:      n_accepted++;
              ST_INVALID: n_invalid++;
              default:    n_region++;
            endcase
          end
        end
      end
      req_taken = in_valid_i && in_ready_o;
      if (req_taken) expected_verdicts.push_back(predict_verdict(cur_req));
    end
  end

  // ------------------------------------------------------------ stimulus

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // value in [0, lim], leaning toward small values and the bound itself
  function automatic logic [63:0] pick_below(logic [63:0] lim);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 64'($urandom_range(0, (lim < 64'd4095) ? lim[31:0] : 4095));
    if (roll < 50) return lim;
    if (lim == '1) return rand64();
    return rand64() % (lim + 64'd1);
  endfunction

  function automatic elf_req_t noise_req();
    elf_req_t r;
    r.op           = op_e'($urandom_range(0, 1));
    r.ident        = 56'(rand64());
    r.file_type    = 16'($urandom);
    r.machine      = 16'($urandom);
    r.entry_size   = 16'($urandom);
    r.header_count = 16'($urandom);
    r.offset       = rand64();
    r.address      = rand64();
    r.seg_type     = $urandom;
    r.file_size    = rand64();
    r.mem_size     = rand64();
    return r;
  endfunction

  function automatic elf_req_t file_hdr(logic [15:0] count, logic [63:0] tbl_off,
                                        logic [63:0] entry);
    elf_req_t r;
    r              = noise_req();
    r.op           = OP_FILE_HDR;
    r.ident        = IDENT_GOOD;
    r.file_type    = TYPE_EXEC;
    r.machine      = MACH_X86_64;
    r.entry_size   = PHDR_BYTES;
    r.header_count = count;
    r.offset       = tbl_off;
    r.address      = entry;
    return r;
  endfunction

  function automatic elf_req_t prog_hdr(logic [31:0] stype, logic [63:0] off,
                                        logic [63:0] va, logic [63:0] fsz,
                                        logic [63:0] msz);
    elf_req_t r;
    r           = noise_req();
    r.op        = OP_PROG_HDR;
    r.seg_type  = stype;
    r.offset    = off;
    r.address   = va;
    r.file_size = fsz;
    r.mem_size  = msz;
    return r;
  endfunction

  task automatic queue_req(elf_req_t r);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_IMAGE_BYTES:  img_bytes_cfg = val;
      CFG_REGION_START: region_base_cfg = val;
      default:          region_len_cfg = val;
    endcase
  endtask

  task automatic program_layout(logic [63:0] img, logic [63:0] base, logic [63:0] len);
    write_reg(CFG_IMAGE_BYTES, img);
    write_reg(CFG_REGION_START, base);
    write_reg(CFG_REGION_BYTES, len);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold off until every queued request has been answered
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // one image: header, then its program headers; optionally cut short
  task automatic send_image(bit truncate);
    elf_req_t segs[$];
    logic [63:0] lo, hi, entry, tbl_len, off, va, fsz, msz;
    int unsigned count, roll, keep;
    count = $urandom_range(1, 6);
    if (64'(count * 56) > img_bytes_cfg) count = 1;
    tbl_len = 64'(count * 56);
    lo = '1;
    hi = '0;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      msz  = pick_below(region_len_cfg);
      fsz  = pick_below((msz < img_bytes_cfg) ? msz : img_bytes_cfg);
      off  = pick_below(img_bytes_cfg - fsz);
      va   = region_base_cfg + pick_below(region_len_cfg - msz);
      if (roll < 10) begin
        segs.push_back(prog_hdr($urandom | PtDynamic, off, va, fsz, msz));
      end else if (roll < 15) begin
        case ($urandom_range(0, 3))
          0: fsz = msz + 64'd1 + 64'($urandom_range(0, 255));
          1: off = img_bytes_cfg - fsz + 64'd1 + 64'($urandom_range(0, 15));
          2: va = region_base_cfg - 64'd1 - 64'($urandom_range(0, 4095));
          default: va = region_base_cfg + region_len_cfg - msz + 64'd1 +
                        64'($urandom_range(0, 15));
        endcase
        segs.push_back(prog_hdr(PT_LOADABLE, off, va, fsz, msz));
      end else begin
        segs.push_back(prog_hdr(PT_LOADABLE, off, va, fsz, msz));
        if (va < lo) lo = va;
        if (va + msz > hi) hi = va + msz;
      end
    end
    roll = $urandom_range(0, 99);
    if (hi > lo && roll < 85) entry = lo + pick_below(hi - lo - 64'd1);
    else if (hi > lo && roll < 90) entry = hi;
    else if (roll < 95) entry = lo - 64'd1;
    else entry = rand64();
    if (tbl_len <= img_bytes_cfg) off = pick_below(img_bytes_cfg - tbl_len);
    else off = rand64();
    queue_req(file_hdr(16'(count), off, entry));
    keep = truncate ? $urandom_range(0, count - 1) : count;
    for (int i = 0; i < keep; i++) queue_req(segs[i]);
  endtask

  // header with one field spoiled, or a noise header
  task automatic send_bad_header();
    elf_req_t r;
    r = file_hdr(16'($urandom_range(1, 4)), 64'd0, rand64());
    case ($urandom_range(0, 6))
      0: r.ident = r.ident ^ (56'd1 << $urandom_range(0, 55));
      1: r.file_type = 16'($urandom);
      2: r.machine = 16'($urandom);
      3: r.entry_size = 16'($urandom);
      4: r.header_count = 16'd0;
      5: r.offset = img_bytes_cfg - 64'(r.header_count) * 64'(PHDR_BYTES) +
                    64'd1 + 64'($urandom_range(0, 63));
      default: r = noise_req();
    endcase
    r.op = OP_FILE_HDR;
    queue_req(r);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned goal, roll;
    goal = reqs_queued + n;
    while (reqs_queued < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) send_image(1'b0);
      else if (roll < 80) send_image(1'b1);
      else if (roll < 88) send_bad_header();
      else if (roll < 94) queue_req(prog_hdr(PT_LOADABLE, rand64(), rand64(),
                                             rand64(), rand64()));
      else queue_req(noise_req());
    end
    drain();
  endtask

  task automatic run_directed();
    elf_req_t r;
    r = file_hdr(16'd1, 64'd64, RegionBase);
    r.ident = IDENT_GOOD ^ 56'h100;
    queue_req(r);
    r = file_hdr(16'd1, 64'd64, RegionBase);
    r.file_type = TYPE_EXEC + 16'd1;
    queue_req(r);
    r = file_hdr(16'd1, 64'd64, RegionBase);
    r.machine = ~MACH_X86_64;
    queue_req(r);
    r = file_hdr(16'd1, 64'd64, RegionBase);
    r.entry_size = PHDR_BYTES + 16'd8;
    queue_req(r);
    queue_req(file_hdr(16'd0, 64'd64, RegionBase));
    // header table one byte past the image end
    queue_req(file_hdr(16'd2, ImageSize - 64'd111, RegionBase));
    // clean image, table and one segment ending exactly at the image end
    queue_req(file_hdr(16'd3, ImageSize - 64'd168, RegionBase + 64'h100));
    queue_req(prog_hdr(PtNote, 64'd0, 64'd0, 64'd0, 64'd0));
    queue_req(prog_hdr(PT_LOADABLE, ImageSize - 64'h800, RegionBase, 64'h800, 64'h1000));
    queue_req(prog_hdr(PT_LOADABLE, 64'd0, RegionBase + 64'h2000, 64'h10, 64'h10));
    // segment request after the verdict
    queue_req(prog_hdr(PT_LOADABLE, 64'd0, RegionBase, 64'd0, 64'd0));
    queue_req(file_hdr(16'd2, 64'd64, RegionBase));
    queue_req(prog_hdr(PT_LOADABLE, 64'd0, RegionBase, 64'h20, 64'h1f));
    queue_req(file_hdr(16'd2, 64'd64, RegionBase));
    queue_req(prog_hdr(PT_LOADABLE, 64'd0, RegionBase - 64'd1, 64'd0, 64'h10));
    // entry at the end of the span is outside it
    queue_req(file_hdr(16'd1, 64'd64, RegionBase + 64'h1000));
    queue_req(prog_hdr(PT_LOADABLE, 64'd0, RegionBase, 64'h100, 64'h1000));
    // no loadable segment
    queue_req(file_hdr(16'd1, 64'd64, RegionBase));
    queue_req(prog_hdr(PtDynamic, 64'd0, RegionBase, 64'd0, 64'd0));
    // new header in the middle of an image restarts tracking
    queue_req(file_hdr(16'd3, 64'd64, RegionBase));
    queue_req(prog_hdr(PT_LOADABLE, 64'd0, RegionBase, 64'h40, 64'h40));
    queue_req(file_hdr(16'd1, 64'd64, RegionBase + 64'd4));
    queue_req(prog_hdr(PT_LOADABLE, 64'h40, RegionBase, 64'h40, 64'h80));
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: nothing can be valid
    queue_req(prog_hdr(PT_LOADABLE, 64'd0, 64'd0, 64'd0, 64'd0));
    queue_req(file_hdr(16'd1, 64'd0, 64'd0));
    drain();

    program_layout(ImageSize, RegionBase, RegionSize);
    run_directed();
    run_random(250);

    // full range, no stalls on either side
    calm = 1'b1;
    program_layout('1, 64'd0, '1);
    run_random(150);
    calm = 1'b0;

    // region at the top of memory, segment ends wrap
    program_layout('1, 64'hFFFF_FFFF_FFFF_0000, '1);
    run_random(130);

    // smallest image that holds a header
    program_layout(EHDR_BYTES, 64'h1000, 64'h40);
    run_random(100);
    program_layout(EHDR_BYTES - 64'd1, 64'h1000, 64'h40);
    run_random(30);

    // empty region
    program_layout(64'h1_0000, rand64(), 64'd0);
    run_random(40);

    program_layout(ImageSize, RegionBase, RegionSize);
    run_random(150);

    $display("%0d requests, %0d results checked", reqs_queued, results_checked);
    $display("verdicts: %0d accepted, %0d invalid, %0d outside region",
             n_accepted, n_invalid, n_region);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
